FILE: rtl/core/mer_pkg.sv
// shared widths, configuration register indexes, command and status types
// for the midpoint ellipse rasterizer; no dependencies
package mer_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int OUT_W      = COORD_BITS + 2;
  localparam int MUL_W      = 2 * COORD_BITS + 2;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DXY_W      = SQ_W + OUT_W + 1;
  localparam int INC_W      = DXY_W + 1;
  localparam int DEC_W      = 4 * COORD_BITS + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_FILL     = CFG_IDX_W'(4);

  typedef enum logic [2:0] {
    MUL_RXRX,
    MUL_RYRY,
    MUL_A2RY,
    MUL_TXTX,
    MUL_B2P,
    MUL_TYTY,
    MUL_A2P,
    MUL_A2B2
  } mul_sel_e;

  typedef enum logic [2:0] {
    D_HOLD,
    D_INIT,
    D_ACC,
    D_LOAD_P,
    D_ADD4P,
    D_SUB4P
  } d_op_e;

  typedef struct packed {
    mul_sel_e   mul_sel;
    d_op_e      d_op;
    logic       ld_a2;
    logic       ld_b2;
    logic       init;
    logic       snap;
    logic       adv;
    logic       calc_inc;
    logic       region;
    logic       emit_ld;
    logic       emit_nopix;
    logic       emit_last;
    logic       emit_fin;
    logic [1:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic dx_gt_dy;
    logic y_neg;
    logic fill;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/midpoint_ellipse_rasterizer.sv
// restart: accepted in idle, then S1 to S4 square the radii on one shared multiplier and initialise;
// step: ADV, INC, UPD advance the decision, RC1 to RC6 on the step entering region two,
// then one result per cycle from the output register (4 outline, 2 fill), held while stalled;
// an idle step, with no ellipse active, gives a single no-pixel result
// reset: asynchronous active low, configuration cleared to zero, no ellipse active
module midpoint_ellipse_rasterizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mer_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mer_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mer_pkg::OUT_W-1:0]    span_x_left_o,
  output logic signed [mer_pkg::OUT_W-1:0]    span_x_right_o,
  output logic signed [mer_pkg::OUT_W-1:0]    span_y_o,
  output logic                                no_pixel_o,
  output logic                                last_of_step_o,
  output logic                                finished_o
);
  import mer_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mer_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .span_x_left_o  (span_x_left_o),
    .span_x_right_o (span_x_right_o),
    .span_y_o       (span_y_o),
    .no_pixel_o     (no_pixel_o),
    .last_of_step_o (last_of_step_o),
    .finished_o     (finished_o)
  );

endmodule

FILE: rtl/core/mer_datapath.sv
// datapath: configuration registers, shared multiplier, step and decision
// registers, output register; uses mer_pkg
module mer_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mer_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mer_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  mer_pkg::cmd_t                       cmd_i,
  output mer_pkg::sts_t                       sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [mer_pkg::OUT_W-1:0]    span_x_left_o,
  output logic signed [mer_pkg::OUT_W-1:0]    span_x_right_o,
  output logic signed [mer_pkg::OUT_W-1:0]    span_y_o,
  output logic                                no_pixel_o,
  output logic                                last_of_step_o,
  output logic                                finished_o
);
  import mer_pkg::*;

  logic [COORD_BITS-1:0]   cx_q, cy_q;
  logic [RAD_W-1:0]        rx_q, ry_q;
  logic                    fill_q;

  logic [SQ_W-1:0]         a2_q, b2_q;
  logic [MUL_W-1:0]        op_a, op_b;
  logic [PROD_W-1:0]       prod_q;

  logic signed [OUT_W-1:0] x_q, y_q, ox_q, oy_q;
  logic signed [DXY_W-1:0] dx_q, dy_q, two_a2, two_b2;
  logic signed [DEC_W-1:0] d_q, d_d;
  logic signed [INC_W-1:0] inc_q, inc_n, dx_e, dy_e, k_e;
  logic                    br_q, br_n, inc_x, dec_y, use_dx, use_dy;

  logic [OUT_W:0]          tx_w, ty_abs;
  logic signed [OUT_W:0]   ty_w;
  logic signed [DEC_W-1:0] p_d, a2_d, b2_d, inc_d;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] cx_e, cy_e, xp, xm, yp, ym;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      rx_q   <= '0;
      ry_q   <= '0;
      fill_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X: cx_q   <= cfg_data_i;
        CFG_CENTER_Y: cy_q   <= cfg_data_i;
        CFG_RADIUS_X: rx_q   <= cfg_data_i[RAD_W-1:0];
        CFG_RADIUS_Y: ry_q   <= cfg_data_i[RAD_W-1:0];
        CFG_FILL:     fill_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  assign tx_w   = {x_q, 1'b1};
  assign ty_w   = (OUT_W+1)'(y_q) - (OUT_W+1)'(1);
  assign ty_abs = ty_w[OUT_W] ? (OUT_W+1)'(-ty_w) : (OUT_W+1)'(ty_w);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RXRX: begin op_a = MUL_W'(rx_q);   op_b = MUL_W'(rx_q);           end
      MUL_RYRY: begin op_a = MUL_W'(ry_q);   op_b = MUL_W'(ry_q);           end
      MUL_A2RY: begin op_a = MUL_W'(a2_q);   op_b = MUL_W'(ry_q);           end
      MUL_TXTX: begin op_a = MUL_W'(tx_w);   op_b = MUL_W'(tx_w);           end
      MUL_B2P:  begin op_a = MUL_W'(b2_q);   op_b = prod_q[MUL_W-1:0];      end
      MUL_TYTY: begin op_a = MUL_W'(ty_abs); op_b = MUL_W'(ty_abs);         end
      MUL_A2P:  begin op_a = MUL_W'(a2_q);   op_b = prod_q[MUL_W-1:0];      end
      MUL_A2B2: begin op_a = MUL_W'(a2_q);   op_b = MUL_W'(b2_q);           end
      default:  begin op_a = '0;             op_b = '0;                     end
    endcase
  end

  // step direction
  always_comb begin
    if (!cmd_i.region) begin
      br_n  = d_q[DEC_W-1];
      inc_x = 1'b1;
      dec_y = !br_n;
    end else begin
      br_n  = !d_q[DEC_W-1] && (d_q != '0);
      dec_y = 1'b1;
      inc_x = !br_n;
    end
  end

  assign two_a2 = signed'(DXY_W'({a2_q, 1'b0}));
  assign two_b2 = signed'(DXY_W'({b2_q, 1'b0}));

  // decision increment
  assign use_dx = !(cmd_i.region && br_q);
  assign use_dy = !(!cmd_i.region && br_q);
  assign dx_e   = INC_W'(dx_q);
  assign dy_e   = INC_W'(dy_q);
  assign k_e    = signed'(INC_W'(cmd_i.region ? a2_q : b2_q));
  assign inc_n  = (use_dx ? dx_e : '0) - (use_dy ? dy_e : '0) + k_e;

  // decision update
  assign p_d   = signed'(DEC_W'(prod_q));
  assign a2_d  = signed'(DEC_W'(a2_q));
  assign b2_d  = signed'(DEC_W'(b2_q));
  assign inc_d = DEC_W'(inc_q);

  always_comb begin
    case (cmd_i.d_op)
      D_HOLD:   d_d = d_q;
      D_INIT:   d_d = (b2_d <<< 2) - (p_d <<< 2) + a2_d;
      D_ACC:    d_d = d_q + (inc_d <<< 2);
      D_LOAD_P: d_d = p_d;
      D_ADD4P:  d_d = d_q + (p_d <<< 2);
      D_SUB4P:  d_d = d_q - (p_d <<< 2);
      default:  d_d = d_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    d_q    <= d_d;
    if (cmd_i.ld_a2) a2_q <= prod_q[SQ_W-1:0];
    if (cmd_i.ld_b2) b2_q <= prod_q[SQ_W-1:0];
    if (cmd_i.calc_inc) inc_q <= inc_n;
    if (cmd_i.snap) begin
      ox_q <= x_q;
      oy_q <= y_q;
    end
    if (cmd_i.init) begin
      x_q  <= '0;
      y_q  <= signed'(OUT_W'(ry_q));
      dx_q <= '0;
      dy_q <= signed'(DXY_W'({prod_q[SQ_W+RAD_W-1:0], 1'b0}));
    end else if (cmd_i.adv) begin
      br_q <= br_n;
      if (inc_x) begin
        x_q  <= x_q + OUT_W'(1);
        dx_q <= dx_q + two_b2;
      end
      if (dec_y) begin
        y_q  <= y_q - OUT_W'(1);
        dy_q <= dy_q - two_a2;
      end
    end
  end

  assign sts_o.dx_gt_dy = dx_q > dy_q;
  assign sts_o.y_neg    = y_q[OUT_W-1];
  assign sts_o.fill     = fill_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // output register
  assign cx_e = signed'(OUT_W'(cx_q));
  assign cy_e = signed'(OUT_W'(cy_q));
  assign xp   = cx_e + ox_q;
  assign xm   = cx_e - ox_q;
  assign yp   = cy_e + oy_q;
  assign ym   = cy_e - oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      no_pixel_o     <= cmd_i.emit_nopix;
      last_of_step_o <= cmd_i.emit_last;
      finished_o     <= cmd_i.emit_fin;
      if (cmd_i.emit_nopix) begin
        span_x_left_o  <= '0;
        span_x_right_o <= '0;
        span_y_o       <= '0;
      end else if (fill_q) begin
        span_x_left_o  <= xm;
        span_x_right_o <= xp;
        span_y_o       <= cmd_i.emit_idx[0] ? ym : yp;
      end else begin
        span_x_left_o  <= cmd_i.emit_idx[0] ? xm : xp;
        span_x_right_o <= cmd_i.emit_idx[0] ? xm : xp;
        span_y_o       <= cmd_i.emit_idx[1] ? ym : yp;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/mer_ctrl.sv
// controller: sequences setup, step advance, region change and emission
// uses mer_pkg command and status types
module mer_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          restart_i,
  output logic          in_ready_o,
  input  mer_pkg::sts_t sts_i,
  output mer_pkg::cmd_t cmd_o
);
  import mer_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_S1   = 4'd1;
  localparam logic [3:0] ST_S2   = 4'd2;
  localparam logic [3:0] ST_S3   = 4'd3;
  localparam logic [3:0] ST_S4   = 4'd4;
  localparam logic [3:0] ST_ADV  = 4'd5;
  localparam logic [3:0] ST_INC  = 4'd6;
  localparam logic [3:0] ST_UPD  = 4'd7;
  localparam logic [3:0] ST_RC1  = 4'd8;
  localparam logic [3:0] ST_RC2  = 4'd9;
  localparam logic [3:0] ST_RC3  = 4'd10;
  localparam logic [3:0] ST_RC4  = 4'd11;
  localparam logic [3:0] ST_RC5  = 4'd12;
  localparam logic [3:0] ST_RC6  = 4'd13;
  localparam logic [3:0] ST_EMIT = 4'd14;

  localparam logic [1:0] IDX_LAST_FILL    = 2'd1;
  localparam logic [1:0] IDX_LAST_OUTLINE = 2'd3;

  logic [3:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       nopix_q, nopix_d;
  logic       region_q, region_d;
  logic       active_q, active_d;
  logic       last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign last = nopix_q || (cnt_q == (sts_i.fill ? IDX_LAST_FILL : IDX_LAST_OUTLINE));

  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = MUL_RXRX;
    cmd_o.d_op       = D_HOLD;
    cmd_o.region     = region_q;
    cmd_o.emit_idx   = cnt_q;
    cmd_o.emit_nopix = nopix_q;
    cmd_o.emit_last  = last;
    cmd_o.emit_fin   = !active_q && !nopix_q;
    state_d          = state_q;
    cnt_d            = cnt_q;
    nopix_d          = nopix_q;
    region_d         = region_q;
    active_d         = active_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            state_d = ST_S1;
          end else if (!active_q) begin
            nopix_d = 1'b1;
            state_d = ST_EMIT;
          end else begin
            cmd_o.snap = 1'b1;
            nopix_d    = 1'b0;
            state_d    = ST_ADV;
          end
        end
      end
      ST_S1: begin
        cmd_o.mul_sel = MUL_RXRX;
        state_d       = ST_S2;
      end
      ST_S2: begin
        cmd_o.ld_a2   = 1'b1;
        cmd_o.mul_sel = MUL_RYRY;
        state_d       = ST_S3;
      end
      ST_S3: begin
        cmd_o.ld_b2   = 1'b1;
        cmd_o.mul_sel = MUL_A2RY;
        state_d       = ST_S4;
      end
      ST_S4: begin
        cmd_o.init = 1'b1;
        cmd_o.d_op = D_INIT;
        region_d   = 1'b0;
        active_d   = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = ST_INC;
      end
      ST_INC: begin
        cmd_o.calc_inc = 1'b1;
        state_d        = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.d_op = D_ACC;
        if (!region_q && sts_i.dx_gt_dy) begin
          state_d = ST_RC1;
        end else begin
          if (region_q && sts_i.y_neg) begin
            active_d = 1'b0;
          end
          state_d = ST_EMIT;
        end
      end
      ST_RC1: begin
        cmd_o.mul_sel = MUL_TXTX;
        state_d       = ST_RC2;
      end
      ST_RC2: begin
        cmd_o.mul_sel = MUL_B2P;
        state_d       = ST_RC3;
      end
      ST_RC3: begin
        cmd_o.d_op    = D_LOAD_P;
        cmd_o.mul_sel = MUL_TYTY;
        state_d       = ST_RC4;
      end
      ST_RC4: begin
        cmd_o.mul_sel = MUL_A2P;
        state_d       = ST_RC5;
      end
      ST_RC5: begin
        cmd_o.d_op    = D_ADD4P;
        cmd_o.mul_sel = MUL_A2B2;
        state_d       = ST_RC6;
      end
      ST_RC6: begin
        cmd_o.d_op = D_SUB4P;
        region_d   = 1'b1;
        active_d   = !sts_i.y_neg;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          if (last) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      nopix_q  <= 1'b0;
      region_q <= 1'b0;
      active_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      nopix_q  <= nopix_d;
      region_q <= region_d;
      active_q <= active_d;
    end
  end

endmodule

FILE: rtl/core/mer_checker.sv
// port-level checks for the midpoint ellipse rasterizer
// uses mer_pkg widths; bound to the top level below
module mer_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [mer_pkg::OUT_W-1:0]    span_x_left_o,
  input logic signed [mer_pkg::OUT_W-1:0]    span_x_right_o,
  input logic signed [mer_pkg::OUT_W-1:0]    span_y_o,
  input logic                                no_pixel_o,
  input logic                                last_of_step_o,
  input logic                                finished_o
);
  import mer_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(span_x_left_o)
      && $stable(span_x_right_o) && $stable(span_y_o) && $stable(last_of_step_o))
    else $error("output transaction changed while stalled");

  a_nopix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_pixel_o |-> last_of_step_o && !finished_o
      && span_x_left_o == '0 && span_x_right_o == '0 && span_y_o == '0)
    else $error("empty result not a lone zero transaction");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again before the previous one was handled");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_step_o |=> out_valid_o)
    else $error("gap inside the results of one step");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);
